### design/rle_enc_pkg.sv
// Shared types, constants and helper functions for the run-length encoder.
// Used by rle_enc_run, rle_enc_ser and rle_ascii_decimal_encoder_core.
package rle_enc_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int RUN_CAP         = 99999;
  localparam int BCD_DIGITS      = 5;
  localparam int BCD_W           = 4 * BCD_DIGITS;

  localparam logic [7:0] ASCII_ZERO = 8'h30;

  typedef logic [2:0] ndig_t;

  typedef struct packed {
    logic [BCD_W-1:0] bcd;
    ndig_t            ndig;
    logic [7:0]       val;
  } run_t;

  typedef struct packed {
    run_t second;
    run_t first;
    logic two;
    logic fin;
  } job_t;

  function automatic logic [BCD_W-1:0] bcd_inc(input logic [BCD_W-1:0] v);
    logic [BCD_W-1:0] r;
    logic             carry;
    r     = v;
    carry = 1'b1;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (carry) begin
        if (v[4*i +: 4] == 4'd9) begin
          r[4*i +: 4] = 4'd0;
        end else begin
          r[4*i +: 4] = v[4*i +: 4] + 4'd1;
          carry       = 1'b0;
        end
      end
    end
    return r;
  endfunction

  function automatic ndig_t bcd_len(input logic [BCD_W-1:0] v);
    ndig_t n;
    n = ndig_t'(1);
    for (int i = 1; i < BCD_DIGITS; i++) begin
      if (v[4*i +: 4] != 4'd0) begin
        n = ndig_t'(i + 1);
      end
    end
    return n;
  endfunction

endpackage

### design/rle_enc_run.sv
// Run tracker: holds the current byte and its length in binary and decimal.
// Builds the runs to emit for each accepted request. Depends on rle_enc_pkg.
module rle_enc_run #(
  parameter int COUNT_WIDTH = rle_enc_pkg::COUNT_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        data_byte,
  input  logic              final_byte,
  output logic              job_load,
  output rle_enc_pkg::job_t job
);
  import rle_enc_pkg::*;

  localparam int CNT_W     = (COUNT_WIDTH > 17) ? 17 : COUNT_WIDTH;
  localparam int RUN_LIMIT = (COUNT_WIDTH >= 17) ? RUN_CAP : (1 << COUNT_WIDTH) - 1;
  localparam logic [CNT_W-1:0] LIMIT = CNT_W'(RUN_LIMIT);

  logic [7:0]       held_byte, held_byte_next, cont_byte;
  logic [CNT_W-1:0] run_bin, run_bin_next, cont_bin;
  logic [BCD_W-1:0] run_bcd, run_bcd_next, cont_bcd;
  logic             holding, holding_next;
  logic             emit_a;
  run_t             run_a, run_b;

  always_comb begin
    emit_a    = 1'b0;
    cont_byte = held_byte;
    cont_bin  = run_bin;
    cont_bcd  = run_bcd;
    if (!holding) begin
      cont_byte = data_byte;
      cont_bin  = CNT_W'(1);
      cont_bcd  = BCD_W'(1);
    end else if (data_byte == held_byte) begin
      if (run_bin >= LIMIT) begin
        emit_a   = 1'b1;
        cont_bin = CNT_W'(1);
        cont_bcd = BCD_W'(1);
      end else begin
        cont_bin = run_bin + CNT_W'(1);
        cont_bcd = bcd_inc(run_bcd);
      end
    end else begin
      emit_a    = 1'b1;
      cont_byte = data_byte;
      cont_bin  = CNT_W'(1);
      cont_bcd  = BCD_W'(1);
    end

    run_a.bcd  = run_bcd;
    run_a.ndig = bcd_len(run_bcd);
    run_a.val  = held_byte;
    run_b.bcd  = cont_bcd;
    run_b.ndig = bcd_len(cont_bcd);
    run_b.val  = cont_byte;

    held_byte_next = held_byte;
    run_bin_next   = run_bin;
    run_bcd_next   = run_bcd;
    holding_next   = holding;
    if (accept) begin
      if (final_byte) begin
        held_byte_next = 8'd0;
        run_bin_next   = '0;
        run_bcd_next   = '0;
        holding_next   = 1'b0;
      end else begin
        held_byte_next = cont_byte;
        run_bin_next   = cont_bin;
        run_bcd_next   = cont_bcd;
        holding_next   = 1'b1;
      end
    end

    job_load   = accept && (emit_a || final_byte);
    job.fin    = final_byte;
    job.two    = emit_a && final_byte;
    job.first  = emit_a ? run_a : run_b;
    job.second = run_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_byte <= 8'd0;
      run_bin   <= '0;
      run_bcd   <= '0;
      holding   <= 1'b0;
    end else begin
      held_byte <= held_byte_next;
      run_bin   <= run_bin_next;
      run_bcd   <= run_bcd_next;
      holding   <= holding_next;
    end
  end

  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    !holding |-> (run_bin == '0 && run_bcd == '0))
    else $error("Run counters not cleared while no run is held.");

  a_run_limit: assert property (@(posedge clk) disable iff (rst)
    run_bin <= LIMIT)
    else $error("Run length exceeds the run limit.");

  a_held_nonzero: assert property (@(posedge clk) disable iff (rst)
    holding |-> run_bin != '0)
    else $error("Held run has zero length.");

endmodule

### design/rle_enc_ser.sv
// Serializer: holds one job of up to two runs; unless stalled, its registered
// output sends one digit or byte per cycle. Depends on rle_enc_pkg.
module rle_enc_ser (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_load,
  input  rle_enc_pkg::job_t job,
  output logic              job_free,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_byte,
  output logic              last_of_item,
  output logic              stream_done
);
  import rle_enc_pkg::*;

  job_t       cur;
  logic       busy;
  logic       slot;
  ndig_t      dig;
  logic       in_byte;
  logic       adv, emit, done, last_run;
  run_t       cur_run;
  logic [3:0] digit;
  logic [7:0] byte_now;
  logic       last_now;

  always_comb begin
    adv      = !out_valid || !out_stall;
    cur_run  = slot ? cur.second : cur.first;
    last_run = !cur.two || slot;
    emit     = busy && adv;
    done     = emit && in_byte && last_run;
    job_free = !busy || done;
    digit    = cur_run.bcd[{dig, 2'b00} +: 4];
    byte_now = in_byte ? cur_run.val : ASCII_ZERO + {4'd0, digit};
    last_now = in_byte && last_run;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      slot      <= 1'b0;
      dig       <= '0;
      in_byte   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv) begin
        out_valid <= busy;
      end
      if (emit) begin
        if (!in_byte) begin
          if (dig == '0) begin
            in_byte <= 1'b1;
          end else begin
            dig <= dig - ndig_t'(1);
          end
        end else if (!last_run) begin
          slot    <= 1'b1;
          dig     <= cur.second.ndig - ndig_t'(1);
          in_byte <= 1'b0;
        end
      end
      if (job_load) begin
        busy    <= 1'b1;
        slot    <= 1'b0;
        dig     <= job.first.ndig - ndig_t'(1);
        in_byte <= 1'b0;
      end else if (done) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_load) begin
      cur <= job;
    end
    if (emit) begin
      out_byte     <= byte_now;
      last_of_item <= last_now;
      stream_done  <= last_now && cur.fin;
    end
  end

  a_dig_range: assert property (@(posedge clk) disable iff (rst)
    (busy && !in_byte) |-> dig < cur_run.ndig)
    else $error("Digit index outside the run's digit count.");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && stream_done) |-> last_of_item)
    else $error("End of stream flagged on a result that does not close its request.");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    job_load |-> job_free)
    else $error("Job loaded while the serializer is still busy.");

  a_second_slot: assert property (@(posedge clk) disable iff (rst)
    (busy && slot) |-> cur.two)
    else $error("Second run sent for a job that holds only one.");

endmodule

### design/rle_ascii_decimal_encoder_core.sv
// Top level of the run-length encoder: byte stream in, ASCII decimal count
// and run byte out. Depends on rle_enc_pkg, rle_enc_run and rle_enc_ser.
//
//   channel | valid     | stall     | payload
//   input   | in_valid  | in_stall  | data_byte, final_byte
//   output  | out_valid | out_stall | out_byte, last_of_item, stream_done
//
// A request that only extends a run gives no result.
// A request that closes a run (a final byte may close two) gives the count
// digits and byte of each, one result per cycle while the output does not
// stall; the next request is taken as the last enters the output register.
// Reset clears the held run and empties the serializer and output register.
// Stalls on the output hold the output register and the job in progress, so
// in_stall stays high until the job's last result has entered that register.
module rle_ascii_decimal_encoder_core #(
  parameter int COUNT_WIDTH = rle_enc_pkg::COUNT_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       final_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       last_of_item,
  output logic       stream_done
);
  import rle_enc_pkg::*;

  logic accept;
  logic job_load;
  logic job_free;
  job_t job;

  assign in_stall = !job_free;
  assign accept   = in_valid && !in_stall;

  rle_enc_run #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_run (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (data_byte),
    .final_byte(final_byte),
    .job_load  (job_load),
    .job       (job)
  );

  rle_enc_ser u_ser (
    .clk         (clk),
    .rst         (rst),
    .job_load    (job_load),
    .job         (job),
    .job_free    (job_free),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .last_of_item(last_of_item),
    .stream_done (stream_done)
  );

endmodule

### tb/sv/rle_enc_checker.sv
// Checker for the run-length encoder: watches both channels, predicts the encoded
// bytes of every accepted request and compares them with the results in order.
// Depends on rle_enc_pkg.
`timescale 1ns / 100ps
module rle_enc_checker #(
  parameter int COUNT_WIDTH = rle_enc_pkg::COUNT_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       final_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_byte,
  input  logic       last_of_item,
  input  logic       stream_done,
  output int         errors,
  output int         pending,
  output int         results_seen,
  output int         streams_seen
);
  import rle_enc_pkg::*;

  localparam int unsigned RUN_LIMIT =
    (COUNT_WIDTH >= 17) ? RUN_CAP : int'((64'd1 << COUNT_WIDTH) - 1);

  typedef struct packed {
    logic [7:0] value;
    logic       item_end;
    logic       stream_end;
  } enc_byte_t;

  enc_byte_t   expected_bytes[$];
  enc_byte_t   item_bytes[0:15];
  int          n_item;
  logic [7:0]  held;
  int unsigned run_len;
  logic        holding;
  enc_byte_t   want;
  enc_byte_t   got;

  task automatic append_run(input int unsigned count, input logic [7:0] value);
    logic [7:0]  digits[0:9];
    int          nd;
    int unsigned v;
    nd = 0;
    v  = count;
    do begin
      digits[nd] = ASCII_ZERO + 8'(v % 10);
      nd++;
      v = v / 10;
    end while (v != 0);
    for (int i = nd - 1; i >= 0; i--) begin
      item_bytes[n_item] = '{digits[i], 1'b0, 1'b0};
      n_item++;
    end
    item_bytes[n_item] = '{value, 1'b0, 1'b0};
    n_item++;
  endtask

  task automatic encode_byte(input logic [7:0] b, input logic fin);
    n_item = 0;
    if (!holding) begin
      held    = b;
      run_len = 1;
      holding = 1'b1;
    end else if (b == held) begin
      if (run_len >= RUN_LIMIT) begin
        append_run(run_len, held);
        run_len = 1;
      end else begin
        run_len++;
      end
    end else begin
      append_run(run_len, held);
      held    = b;
      run_len = 1;
    end
    if (fin) begin
      append_run(run_len, held);
      held    = 8'h00;
      run_len = 0;
      holding = 1'b0;
    end
    if (n_item > 0) begin
      item_bytes[n_item - 1].item_end   = 1'b1;
      item_bytes[n_item - 1].stream_end = fin;
    end
    for (int i = 0; i < n_item; i++) begin
      expected_bytes.push_back(item_bytes[i]);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      expected_bytes.delete();
      held         = 8'h00;
      run_len      = 0;
      holding      = 1'b0;
      errors       = 0;
      results_seen = 0;
      streams_seen = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{out_byte, last_of_item, stream_done};
        results_seen++;
        if (stream_done) begin
          streams_seen++;
        end
        if (expected_bytes.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: expected none, actual byte=%h last=%b done=%b",
                   $time, got.value, got.item_end, got.stream_end);
        end else begin
          want = expected_bytes.pop_front();
          if (got.value !== want.value || got.item_end !== want.item_end ||
              got.stream_end !== want.stream_end) begin
            errors++;
            $display("%0t: mismatch: expected byte=%h last=%b done=%b, actual byte=%h last=%b done=%b",
                     $time, want.value, want.item_end, want.stream_end,
                     got.value, got.item_end, got.stream_end);
          end
        end
      end
      if (in_valid && !in_stall) begin
        encode_byte(data_byte, final_byte);
      end
    end
    pending = expected_bytes.size();
  end

endmodule

### tb/sv/tb.sv
// Testbench top for rle_ascii_decimal_encoder_core: clock, reset, byte stream
// stimulus under several idle and stall mixes, and the verdict.
// Depends on rle_enc_pkg, the encoder RTL and rle_enc_checker.
`timescale 1ns / 100ps
module tb;
  import rle_enc_pkg::*;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] data_byte;
  logic       final_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       last_of_item;
  logic       stream_done;

  int errors;
  int pending;
  int results_seen;
  int streams_seen;
  int idle_pct;
  int stall_pct;
  int requests_sent;
  int phase_start;
  int idle_mix[4]  = '{0, 85, 0, 19};
  int stall_mix[4] = '{0, 0, 85, 19};

  rle_ascii_decimal_encoder_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .final_byte   (final_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .last_of_item (last_of_item),
    .stream_done  (stream_done)
  );

  rle_enc_checker i_check (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .final_byte   (final_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .last_of_item (last_of_item),
    .stream_done  (stream_done),
    .errors       (errors),
    .pending      (pending),
    .results_seen (results_seen),
    .streams_seen (streams_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  always @(negedge clk) begin
    out_stall <= !rst && ($urandom_range(99) < stall_pct);
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    data_byte  <= b;
    final_byte <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic send_run(input logic [7:0] b, input int len, input logic fin);
    for (int i = 0; i < len; i++) begin
      send_byte(b, fin && (i == len - 1));
    end
  endtask

  task automatic send_random_stream();
    int         runs;
    int         len;
    int         r;
    logic [7:0] b;
    b    = 8'($urandom);
    runs = $urandom_range(6, 1);
    for (int k = 0; k < runs; k++) begin
      r = $urandom_range(99);
      if (r < 70) begin
        len = $urandom_range(3, 1);
      end else if (r < 95) begin
        len = $urandom_range(12, 4);
      end else begin
        len = $urandom_range(120, 13);
      end
      if ($urandom_range(5) != 0) begin
        b = 8'($urandom);
      end
      send_run(b, len, k == runs - 1);
    end
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(8, 1);
    for (int i = 0; i < n; i++) begin
      send_byte($urandom_range(1) ? 8'($urandom) : 8'($urandom_range(2)),
                $urandom_range(5) == 0);
    end
  endtask

  task automatic drain_encoder();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    data_byte     = 8'h00;
    final_byte    = 1'b0;
    idle_pct      = 0;
    stall_pct     = 0;
    requests_sent = 0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_run(8'h41, 2, 1'b0);
    send_run(8'h42, 2, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_run(8'h55, 10, 1'b0);
    send_byte(8'hAA, 1'b1);
    send_run(8'h80, 100, 1'b0);
    send_byte(8'h7F, 1'b1);
    drain_encoder();

    for (int p = 0; p < 4; p++) begin
      idle_pct    = idle_mix[p];
      stall_pct   = stall_mix[p];
      phase_start = requests_sent;
      while (requests_sent - phase_start < 15) begin
        if ($urandom_range(4) == 0) begin
          send_noise();
        end else begin
          send_random_stream();
        end
      end
      drain_encoder();
    end

    $display("summary: %0d requests over directed runs and four idle and stall mixes,",
             requests_sent);
    $display("summary: %0d result bytes checked, %0d streams closed",
             results_seen, streams_seen);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### rle_ascii_decimal_encoder_core.f
design/rle_enc_pkg.sv
design/rle_enc_run.sv
design/rle_enc_ser.sv
design/rle_ascii_decimal_encoder_core.sv
tb/sv/rle_enc_checker.sv
tb/sv/tb.sv
